// File: design/page_run_allocator_defines.svh
// Assertion macros for the page run allocator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define PAGE_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pra_pkg.sv
// Shared constants for the page run allocator: field widths, page states,
// operation kinds, status codes and configuration register indexes. No dependencies.
package pra_pkg;

  localparam int MAX_PAGES_DEF = 1024;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int PB_W          = 17;
  localparam int DIVD_W        = 28;
  localparam int ADDR_W        = 26;
  localparam int SIZE_W        = 27;
  localparam int ABITS_W       = 5;
  localparam int IN_DATA_W     = 112;
  localparam int OUT_DATA_W    = 56;

  localparam logic [1:0] ST_NEVER = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_HEAD  = 2'd2;
  localparam logic [1:0] ST_CONT  = 2'd3;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_RESIZE = 2'd3;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BADPARM = 3'd1;
  localparam logic [2:0] STS_NOMEM   = 3'd2;
  localparam logic [2:0] STS_BADADDR = 3'd3;
  localparam logic [2:0] STS_MOVE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_UNITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;

  localparam logic [CFG_W-1:0] PAGE_UNITS_RST   = 11'd64;
  localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 11'd1024;

endpackage

// File: design/pra_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pra_pkg for widths.
module pra_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pra_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [pra_pkg::PB_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [pra_pkg::DIVD_W-1:0]  quot_o,
  output logic [pra_pkg::PB_W-1:0]    rem_o
);

  logic [pra_pkg::DIVD_W-1:0] quo_q;
  logic [pra_pkg::PB_W-1:0]   rem_q;
  logic [pra_pkg::PB_W-1:0]   dsr_q;
  logic [4:0]                 cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [pra_pkg::PB_W:0]     trial;
  logic [pra_pkg::PB_W:0]     diff;
  logic                       ge;

  always_comb begin
    trial = {rem_q, quo_q[pra_pkg::DIVD_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    diff  = trial - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        cnt_q  <= 5'(pra_pkg::DIVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[pra_pkg::PB_W-1:0] : trial[pra_pkg::PB_W-1:0];
        quo_q <= {quo_q[pra_pkg::DIVD_W-2:0], ge};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: design/pra_mem.sv
// Page state memory: one write port, one registered read port, and a
// clearing pass after reset. Depends on pra_pkg for page states.
module pra_mem #(
  parameter int DEPTH = pra_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  output logic          busy_o
);

  logic [1:0]  mem_q [DEPTH];
  logic [AW:0] clr_q;
  logic [1:0]  rdata_q;
  logic        busy;

  assign busy = (clr_q != (AW+1)'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      mem_q[clr_q[AW-1:0]] <= pra_pkg::ST_NEVER;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy;

endmodule

// File: design/page_run_allocator.sv
// Page run allocator: first-fit allocator of contiguous page runs.
// Items arrive on s_axis (tuser = kind, tdata = request fields) and one
// result per item leaves on m_axis (tuser = status, tdata = result fields).
// Registers page_units and pages_in_use are written on the cfg channel
// (always ready); the user must write them only while the block is idle,
// which the block itself does not enforce. One item is worked at a time.
// An item takes control steps, up to three divisions (size to pages,
// address to page, old size to pages), a scan of the page memory at one
// entry per cycle and a write sweep at one entry per cycle. The page
// memory has one read and one write port; they set scan and sweep length.
// After reset the page memory is cleared; s_axis_tready stays low until
// the clear is done. The result sits in an output register, so a new
// item is taken while an earlier result waits; a finished item holds in its
// last state while the receiver stalls and the output register is full.
`include "page_run_allocator_defines.svh"

module page_run_allocator #(
  parameter int MAX_PAGES = pra_pkg::MAX_PAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // address[25:0], size_bytes[52:26], old_size_bytes[79:53],
  // align_bits[84:80], align_offset[110:85], allow_realign[111]
  input  logic [pra_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // address_out[25:0], size_out[52:26], dirty_pages[53], zero[55:54]
  output logic [pra_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status[2:0]
  output logic [2:0]                        m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pra_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pra_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int NW  = $clog2(MAX_PAGES + 1);
  localparam int CW  = (NW > pra_pkg::CFG_W) ? NW : pra_pkg::CFG_W;
  localparam int DW  = pra_pkg::DIVD_W;
  localparam int BW  = pra_pkg::PB_W;
  localparam int AW  = pra_pkg::ADDR_W;
  localparam int SW  = pra_pkg::SIZE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ASCAN = 4'd3;
  localparam logic [3:0] S_RSCAN = 4'd4;
  localparam logic [3:0] S_RCHK  = 4'd5;
  localparam logic [3:0] S_GSCAN = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] DV_NEED = 2'd0;
  localparam logic [1:0] DV_ADDR = 2'd1;
  localparam logic [1:0] DV_OLD  = 2'd2;

  logic [3:0]               state_q;
  logic [pra_pkg::CFG_W-1:0] page_units_q, pages_in_use_q;

  logic [1:0]               kind_q;
  logic [AW-1:0]            addr_q, aoff_q;
  logic [SW-1:0]            size_q, old_q;
  logic [pra_pkg::ABITS_W-1:0] abits_q;
  logic                     realign_q;
  logic [BW-1:0]            pb_q;
  logic [CW-1:0]            n_q;

  logic [1:0]               dsel_q;
  logic                     div_start_q;
  logic [DW-1:0]            div_dvd_q;
  logic                     div_done;
  logic [DW-1:0]            div_quot;
  logic [BW-1:0]            div_rem;

  logic [DW-1:0]            need_q, nom_q;
  logic [BW-1:0]            rem_q;
  logic [CW-1:0]            idx_q, len_q, ptr_q, wend_q, cnt_q;
  logic [PW-1:0]            start_q;
  logic                     pend_q, found_q, rd_q, bad_q, whead_q;
  logic [1:0]               wval_q;
  logic [31:0]              acc_q, sacc_q;
  logic [SW-1:0]            lbytes_q;

  logic [2:0]               res_status_q;
  logic [AW-1:0]            res_addr_q;
  logic [SW-1:0]            res_size_q;
  logic                     res_dirty_q;

  logic                     out_valid_q;
  logic [2:0]               out_status_q;
  logic [AW-1:0]            out_addr_q;
  logic [SW-1:0]            out_size_q;
  logic                     out_dirty_q;

  logic                     mem_re, mem_we, mem_busy;
  logic [1:0]               mem_rdata, mem_wdata;

  // combinational helpers
  logic [pra_pkg::CFG_W-1:0] pu_c, pin_c;
  logic [BW-1:0]            pb_c;
  logic [CW-1:0]            n_c, di_c, need_c;
  logic [31:0]              mask_c;
  logic                     scan_al_c, head_al_c, st_free_c, st_used_c, take_c;
  logic [AW-1:0]            base_c;
  logic [CW-1:0]            cnt_new_c;
  logic                     rd_new_c;
  logic [PW-1:0]            start_new_c;
  logic [31:0]              sacc_new_c;
  logic [CW:0]              idx_need_c;
  logic                     in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (page_units_q == '0) begin
      pu_c = pra_pkg::CFG_W'(1);
    end else if (page_units_q > pra_pkg::CFG_W'(1024)) begin
      pu_c = pra_pkg::CFG_W'(1024);
    end else begin
      pu_c = page_units_q;
    end
    pb_c  = {pu_c[BW-7:0], 6'd0};
    pin_c = {pages_in_use_q[pra_pkg::CFG_W-1:2], 2'b00};
    n_c   = (CW'(pin_c) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pin_c);

    di_c      = ptr_q - 1'b1;
    need_c    = need_q[CW-1:0];
    mask_c    = (32'd1 << abits_q) - 32'd1;
    scan_al_c = ((acc_q + 32'(aoff_q)) & mask_c) == 32'd0;
    base_c    = addr_q - AW'(rem_q);
    head_al_c = ((32'(base_c) + 32'(aoff_q)) & mask_c) == 32'd0;
    st_free_c = (mem_rdata == pra_pkg::ST_NEVER) || (mem_rdata == pra_pkg::ST_FREED);
    st_used_c = (mem_rdata == pra_pkg::ST_HEAD) || (mem_rdata == pra_pkg::ST_CONT);

    take_c      = st_free_c && (found_q || scan_al_c);
    cnt_new_c   = found_q ? cnt_q + 1'b1 : CW'(1);
    rd_new_c    = (found_q && rd_q) || (mem_rdata == pra_pkg::ST_FREED);
    start_new_c = found_q ? start_q : di_c[PW-1:0];
    sacc_new_c  = found_q ? sacc_q : acc_q;
    idx_need_c  = (CW+1)'(idx_q) + (CW+1)'(need_c);

    mem_re    = (state_q == S_ASCAN) || (state_q == S_RSCAN) || (state_q == S_GSCAN);
    mem_we    = (state_q == S_WRITE);
    mem_wdata = whead_q ? pra_pkg::ST_HEAD : wval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      page_units_q   <= pra_pkg::PAGE_UNITS_RST;
      pages_in_use_q <= pra_pkg::PAGES_IN_USE_RST;
      out_valid_q    <= 1'b0;
      div_start_q    <= 1'b0;
      pend_q         <= 1'b0;
      found_q        <= 1'b0;
      whead_q        <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pra_pkg::CFG_PAGE_UNITS:   page_units_q   <= cfg_data_i;
          pra_pkg::CFG_PAGES_IN_USE: pages_in_use_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q       <= s_axis_tuser;
            addr_q       <= s_axis_tdata[25:0];
            size_q       <= s_axis_tdata[52:26];
            old_q        <= s_axis_tdata[79:53];
            abits_q      <= s_axis_tdata[84:80];
            aoff_q       <= s_axis_tdata[110:85];
            realign_q    <= s_axis_tdata[111];
            pb_q         <= pb_c;
            n_q          <= n_c;
            res_status_q <= pra_pkg::STS_OK;
            res_addr_q   <= '0;
            res_size_q   <= '0;
            res_dirty_q  <= 1'b0;
            state_q      <= S_PREP;
          end
        end
        S_PREP: begin
          if (kind_q == pra_pkg::KIND_ALLOC || kind_q == pra_pkg::KIND_RESIZE) begin
            if (size_q == '0) begin
              res_status_q <= pra_pkg::STS_BADPARM;
              state_q      <= S_DONE;
            end else begin
              // round up to whole pages
              div_dvd_q   <= DW'(size_q) + DW'(pb_q) - DW'(1);
              dsel_q      <= DV_NEED;
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end
          end else begin
            div_dvd_q   <= DW'(addr_q);
            dsel_q      <= DV_ADDR;
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (dsel_q)
              DV_NEED: begin
                need_q <= div_quot;
                if (div_quot > DW'(n_q)) begin
                  res_status_q <= pra_pkg::STS_NOMEM;
                  state_q      <= S_DONE;
                end else if (kind_q == pra_pkg::KIND_ALLOC) begin
                  ptr_q   <= '0;
                  pend_q  <= 1'b0;
                  found_q <= 1'b0;
                  acc_q   <= '0;
                  state_q <= S_ASCAN;
                end else begin
                  div_dvd_q   <= DW'(addr_q);
                  dsel_q      <= DV_ADDR;
                  div_start_q <= 1'b1;
                end
              end
              DV_ADDR: begin
                rem_q <= div_rem;
                idx_q <= div_quot[CW-1:0];
                if (div_quot >= DW'(n_q)) begin
                  res_status_q <= pra_pkg::STS_BADADDR;
                  state_q      <= S_DONE;
                end else if (kind_q != pra_pkg::KIND_QUERY && old_q != '0) begin
                  div_dvd_q   <= DW'(old_q) + DW'(pb_q) - DW'(1);
                  dsel_q      <= DV_OLD;
                  div_start_q <= 1'b1;
                end else begin
                  ptr_q   <= div_quot[CW-1:0];
                  pend_q  <= 1'b0;
                  state_q <= S_RSCAN;
                end
              end
              DV_OLD: begin
                nom_q   <= div_quot;
                ptr_q   <= idx_q;
                pend_q  <= 1'b0;
                state_q <= S_RSCAN;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ASCAN: begin
          ptr_q  <= ptr_q + 1'b1;
          pend_q <= 1'b1;
          if (pend_q) begin
            acc_q <= acc_q + 32'(pb_q);
            if (take_c) begin
              found_q <= 1'b1;
              cnt_q   <= cnt_new_c;
              rd_q    <= rd_new_c;
              start_q <= start_new_c;
              sacc_q  <= sacc_new_c;
            end else begin
              found_q <= 1'b0;
            end
            if (take_c && cnt_new_c == need_c) begin
              ptr_q       <= CW'(start_new_c);
              wend_q      <= CW'(start_new_c) + need_c;
              whead_q     <= 1'b1;
              wval_q      <= pra_pkg::ST_CONT;
              res_addr_q  <= sacc_new_c[AW-1:0];
              res_dirty_q <= rd_new_c;
              state_q     <= S_WRITE;
            end else if (di_c == n_q - 1'b1) begin
              res_status_q <= pra_pkg::STS_NOMEM;
              state_q      <= S_DONE;
            end
          end
        end
        S_RSCAN: begin
          ptr_q  <= ptr_q + 1'b1;
          pend_q <= 1'b1;
          if (pend_q) begin
            if (di_c == idx_q) begin
              if (mem_rdata != pra_pkg::ST_HEAD) begin
                res_status_q <= pra_pkg::STS_BADADDR;
                state_q      <= S_DONE;
              end else begin
                len_q    <= CW'(1);
                lbytes_q <= SW'(pb_q);
              end
            end else if (di_c < n_q && mem_rdata == pra_pkg::ST_CONT) begin
              len_q    <= len_q + 1'b1;
              lbytes_q <= lbytes_q + SW'(pb_q);
            end else begin
              state_q <= S_RCHK;
            end
          end
        end
        S_RCHK: begin
          priority if (kind_q == pra_pkg::KIND_QUERY) begin
            res_size_q <= lbytes_q;
            state_q    <= S_DONE;
          end else if (old_q != '0 && nom_q > DW'(n_q)) begin
            res_status_q <= pra_pkg::STS_NOMEM;
            state_q      <= S_DONE;
          end else if (old_q != '0 && nom_q != DW'(len_q)) begin
            res_status_q <= pra_pkg::STS_BADADDR;
            state_q      <= S_DONE;
          end else if (kind_q == pra_pkg::KIND_FREE) begin
            ptr_q   <= idx_q;
            wend_q  <= idx_q + len_q;
            whead_q <= 1'b0;
            wval_q  <= pra_pkg::ST_FREED;
            state_q <= S_WRITE;
          end else if (abits_q != '0 && !head_al_c) begin
            res_status_q <= realign_q ? pra_pkg::STS_MOVE : pra_pkg::STS_BADADDR;
            state_q      <= S_DONE;
          end else if (need_c < len_q) begin
            // shrink: release the tail
            ptr_q      <= idx_q + need_c;
            wend_q     <= idx_q + len_q;
            whead_q    <= 1'b0;
            wval_q     <= pra_pkg::ST_FREED;
            res_addr_q <= base_c;
            state_q    <= S_WRITE;
          end else if (need_c == len_q) begin
            res_addr_q <= base_c;
            state_q    <= S_DONE;
          end else if (idx_need_c > (CW+1)'(n_q)) begin
            res_status_q <= pra_pkg::STS_MOVE;
            state_q      <= S_DONE;
          end else begin
            ptr_q      <= idx_q + len_q;
            wend_q     <= idx_need_c[CW-1:0];
            pend_q     <= 1'b0;
            bad_q      <= 1'b0;
            rd_q       <= 1'b0;
            res_addr_q <= base_c;
            state_q    <= S_GSCAN;
          end
        end
        S_GSCAN: begin
          ptr_q  <= ptr_q + 1'b1;
          pend_q <= 1'b1;
          if (pend_q) begin
            bad_q <= bad_q || st_used_c;
            rd_q  <= rd_q || (mem_rdata == pra_pkg::ST_FREED);
            if (di_c == wend_q - 1'b1) begin
              if (bad_q || st_used_c) begin
                res_status_q <= pra_pkg::STS_MOVE;
                res_addr_q   <= '0;
                state_q      <= S_DONE;
              end else begin
                ptr_q       <= idx_q + len_q;
                whead_q     <= 1'b0;
                wval_q      <= pra_pkg::ST_CONT;
                res_dirty_q <= rd_q || (mem_rdata == pra_pkg::ST_FREED);
                state_q     <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          ptr_q   <= ptr_q + 1'b1;
          whead_q <= 1'b0;
          if (ptr_q + 1'b1 == wend_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_addr_q   <= res_addr_q;
            out_size_q   <= res_size_q;
            out_dirty_q  <= res_dirty_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  pra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (pb_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  pra_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (ptr_q[PW-1:0]),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (ptr_q[PW-1:0]),
    .wdata_i (mem_wdata),
    .busy_o  (mem_busy)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !mem_busy;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_dirty_q, out_size_q, out_addr_q};

  `PRA_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "item accepted but idle")
  `PRA_ASSERT_IMP(a_no_write_in_clear, mem_busy, !mem_we, "page write during clear")
  `PRA_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_DIV, "divide done outside wait")

endmodule

// File: sim/page_run_allocator_tb.sv
// Self-checking testbench for page_run_allocator: drives allocate, free, query
// and resize items on the stream input and checks each result against a local
// page-table predictor. Depends on pra_pkg and the page_run_allocator RTL.
`timescale 1ns / 1ps

module page_run_allocator_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [25:0] addr_out;
    logic [26:0] size_out;
    logic        dirty;
  } alloc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [pra_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [pra_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pra_pkg::CFG_W-1:0] cfg_data_i = '0;

  page_run_allocator u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [1:0] pages_model [pra_pkg::MAX_PAGES_DEF];
  int unsigned unit_reg = 64;
  int unsigned count_reg = 1024;
  alloc_result_t pending_results [$];
  int unsigned err_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // head addresses of runs believed live, to aim frees and resizes
  logic [25:0] live_heads [$];

  function automatic longint unsigned page_bytes_now();
    int unsigned u;
    u = unit_reg;
    if (u == 0) u = 1;
    if (u > 1024) u = 1024;
    return longint'(u) * 64;
  endfunction

  function automatic int unsigned managed_pages();
    int unsigned n;
    n = count_reg & ~32'd3;
    if (n > pra_pkg::MAX_PAGES_DEF) n = pra_pkg::MAX_PAGES_DEF;
    return n;
  endfunction

  function automatic bit aligned_at(longint unsigned idx, longint unsigned pb,
                                    logic [4:0] abits, logic [25:0] aoff);
    longint unsigned mask;
    mask = (64'd1 << abits) - 1;
    return ((idx * pb + aoff) & mask) == 0;
  endfunction

  function automatic int unsigned run_len(int unsigned idx, int unsigned n);
    int unsigned len;
    len = 1;
    if (idx >= n || pages_model[idx] != pra_pkg::ST_HEAD) return 0;
    for (int unsigned i = idx + 1; i < n && pages_model[i] == pra_pkg::ST_CONT; i++) len++;
    return len;
  endfunction

  function automatic logic [2:0] find_run(logic [25:0] addr, logic [26:0] old_b,
                                          longint unsigned pb, int unsigned n,
                                          output int unsigned idx,
                                          output int unsigned len);
    longint unsigned i;
    longint unsigned nominal;
    idx = 0;
    len = 0;
    i = addr / pb;
    if (i >= n) return pra_pkg::STS_BADADDR;
    idx = 32'(i);
    len = run_len(idx, n);
    if (len == 0) return pra_pkg::STS_BADADDR;
    if (old_b != 0) begin
      nominal = (old_b + pb - 1) / pb;
      if (nominal > n) return pra_pkg::STS_NOMEM;
      if (nominal != len) return pra_pkg::STS_BADADDR;
    end
    return pra_pkg::STS_OK;
  endfunction

  // Apply one request to the page table and return its result.
  function automatic alloc_result_t apply_request(logic [1:0] kind,
                                                  logic [pra_pkg::IN_DATA_W-1:0] d);
    alloc_result_t r;
    logic [25:0] addr;
    logic [26:0] sz;
    logic [26:0] old_b;
    logic [4:0] abits;
    logic [25:0] aoff;
    logic realign;
    longint unsigned pb;
    longint unsigned need;
    int unsigned n;
    int unsigned idx;
    int unsigned len;
    int unsigned start;
    int unsigned cnt;
    bit found;
    bit done;
    addr = d[25:0];
    sz = d[52:26];
    old_b = d[79:53];
    abits = d[84:80];
    aoff = d[110:85];
    realign = d[111];
    pb = page_bytes_now();
    n = managed_pages();
    r = '0;
    need = 0;
    if (kind == pra_pkg::KIND_ALLOC || kind == pra_pkg::KIND_RESIZE) begin
      if (sz == 0) r.status = pra_pkg::STS_BADPARM;
      else begin
        need = (sz + pb - 1) / pb;
        if (need > n) r.status = pra_pkg::STS_NOMEM;
      end
    end
    if (r.status != pra_pkg::STS_OK) return r;
    case (kind)
      pra_pkg::KIND_ALLOC: begin
        found = 0;
        done = 0;
        start = 0;
        cnt = 0;
        for (int unsigned i = 0; i < n && !done; i++) begin
          if (pages_model[i] == pra_pkg::ST_NEVER || pages_model[i] == pra_pkg::ST_FREED) begin
            if (!found && aligned_at(i, pb, abits, aoff)) begin
              found = 1;
              start = i;
              cnt = 0;
            end
            if (found) begin
              cnt++;
              if (cnt == need) done = 1;
            end
          end else begin
            found = 0;
            cnt = 0;
          end
        end
        if (!done) r.status = pra_pkg::STS_NOMEM;
        else begin
          for (int unsigned i = start; i < start + cnt; i++) begin
            if (pages_model[i] == pra_pkg::ST_FREED) r.dirty = 1;
            pages_model[i] = (i == start) ? pra_pkg::ST_HEAD : pra_pkg::ST_CONT;
          end
          r.addr_out = 26'(longint'(start) * pb);
        end
      end
      pra_pkg::KIND_FREE: begin
        r.status = find_run(addr, old_b, pb, n, idx, len);
        if (r.status == pra_pkg::STS_OK)
          for (int unsigned i = idx; i < idx + len; i++) pages_model[i] = pra_pkg::ST_FREED;
      end
      pra_pkg::KIND_QUERY: begin
        r.status = find_run(addr, 27'd0, pb, n, idx, len);
        if (r.status == pra_pkg::STS_OK) r.size_out = 27'(longint'(len) * pb);
      end
      default: begin
        r.status = find_run(addr, old_b, pb, n, idx, len);
        if (r.status == pra_pkg::STS_OK && abits != 0 && !aligned_at(idx, pb, abits, aoff))
          r.status = realign ? pra_pkg::STS_MOVE : pra_pkg::STS_BADADDR;
        if (r.status == pra_pkg::STS_OK) begin
          if (need < len) begin
            for (int unsigned i = idx + 32'(need); i < idx + len; i++)
              pages_model[i] = pra_pkg::ST_FREED;
          end else if (need > len) begin
            if (longint'(idx) + need > n) r.status = pra_pkg::STS_MOVE;
            else begin
              for (int unsigned i = idx + len; i < idx + 32'(need); i++)
                if (pages_model[i] == pra_pkg::ST_HEAD || pages_model[i] == pra_pkg::ST_CONT)
                  r.status = pra_pkg::STS_MOVE;
              if (r.status == pra_pkg::STS_OK)
                for (int unsigned i = idx + len; i < idx + 32'(need); i++) begin
                  if (pages_model[i] == pra_pkg::ST_FREED) r.dirty = 1;
                  pages_model[i] = pra_pkg::ST_CONT;
                end
            end
          end
          if (r.status == pra_pkg::STS_OK) r.addr_out = 26'(longint'(idx) * pb);
        end
      end
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.addr_out = m_axis_tdata[25:0];
      got.size_out = m_axis_tdata[52:26];
      got.dirty = m_axis_tdata[53];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%0h size=%0h dirty=%0b",
                 $time, got.status, got.addr_out, got.size_out, got.dirty);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: mismatch expected status=%0d addr=%0h size=%0h dirty=%0b",
                   $time, want.status, want.addr_out, want.size_out, want.dirty);
          $display("%0t:          actual   status=%0d addr=%0h size=%0h dirty=%0b",
                   $time, got.status, got.addr_out, got.size_out, got.dirty);
          err_count++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Leaves tvalid high after the accept; the next send replaces the item,
  // and an idle cycle or drain() drops it.
  task automatic send_item(logic [1:0] kind, logic [25:0] addr, logic [26:0] sz,
                           logic [26:0] old_b, logic [4:0] abits,
                           logic [25:0] aoff, logic realign);
    alloc_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser <= kind;
    s_axis_tdata <= {realign, aoff, abits, old_b, sz, addr};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_request(kind, {realign, aoff, abits, old_b, sz, addr});
    pending_results.push_back(r);
    if (kind == pra_pkg::KIND_ALLOC && r.status == pra_pkg::STS_OK)
      live_heads.push_back(r.addr_out);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // leave a quiet gap before any register write
    repeat (2200) @(negedge clk_i);
  endtask

  // Leaves cfg_valid_i high after the write; the caller drops it.
  task automatic write_reg(logic [pra_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_index_i <= idx;
    cfg_data_i <= value[pra_pkg::CFG_W-1:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == pra_pkg::CFG_PAGE_UNITS) unit_reg = value & 32'h7FF;
    else if (idx == pra_pkg::CFG_PAGES_IN_USE) count_reg = value & 32'h7FF;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(int unsigned units, int unsigned pages);
    drain();
    write_reg(pra_pkg::CFG_PAGE_UNITS, units);
    write_reg(pra_pkg::CFG_PAGES_IN_USE, pages);
    cfg_valid_i <= 1'b0;
    live_heads.delete();
  endtask

  function automatic logic [25:0] pick_address();
    int unsigned k;
    if (live_heads.size() != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(live_heads.size() - 1);
      return live_heads[k];
    end
    return 26'($urandom());
  endfunction

  task automatic test_directed();
    longint unsigned pb;
    logic [25:0] head;
    pb = page_bytes_now();
    send_item(pra_pkg::KIND_ALLOC, 0, 0, 0, 0, 0, 0);                  // zero size
    send_item(pra_pkg::KIND_ALLOC, 0, 27'h4000000, 0, 0, 0, 0);        // larger than memory
    send_item(pra_pkg::KIND_ALLOC, 0, 27'(3 * pb), 0, 0, 0, 0);
    send_item(pra_pkg::KIND_ALLOC, 0, 1, 0, 0, 0, 0);
    send_item(pra_pkg::KIND_ALLOC, 0, 100, 0, 16, 26'(pb), 0);         // aligned with offset
    send_item(pra_pkg::KIND_ALLOC, 26'h3FFFFFF, 27'(pb), 0, 26, 0, 1); // max align
    send_item(pra_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0);
    send_item(pra_pkg::KIND_QUERY, 26'(pb), 0, 0, 0, 0, 0);            // continuation
    send_item(pra_pkg::KIND_QUERY, 26'h3FFFFFF, 0, 0, 0, 0, 0);        // past the end
    send_item(pra_pkg::KIND_FREE, 0, 0, 27'(2 * pb), 0, 0, 0);         // wrong old size
    send_item(pra_pkg::KIND_FREE, 0, 0, 27'h4000000, 0, 0, 0);         // old size too big
    send_item(pra_pkg::KIND_RESIZE, 0, 27'(pb), 0, 0, 0, 0);           // shrink
    send_item(pra_pkg::KIND_RESIZE, 0, 27'(2 * pb), 27'(pb), 0, 0, 0); // grow into freed
    send_item(pra_pkg::KIND_RESIZE, 0, 27'(2 * pb), 0, 0, 0, 0);       // same size
    send_item(pra_pkg::KIND_RESIZE, 0, 27'(40 * pb), 0, 0, 0, 0);      // grow blocked
    send_item(pra_pkg::KIND_RESIZE, 0, 0, 0, 0, 0, 0);                 // zero size
    head = 26'(3 * pb);
    send_item(pra_pkg::KIND_RESIZE, head, 27'(pb), 0, 25, 0, 1);       // misaligned, move
    send_item(pra_pkg::KIND_RESIZE, head, 27'(pb), 0, 25, 0, 0);       // misaligned, reject
    send_item(pra_pkg::KIND_FREE, 0, 0, 0, 0, 0, 0);
    send_item(pra_pkg::KIND_FREE, 0, 0, 0, 0, 0, 0);                   // double free
    send_item(pra_pkg::KIND_ALLOC, 0, 27'(pb), 0, 0, 0, 0);            // dirty reuse
    send_item(pra_pkg::KIND_ALLOC, 0, 27'h7FFFFFF, 0, 31, 26'h3FFFFFF, 1);
  endtask

  task automatic random_burst(int unsigned items);
    longint unsigned pb;
    logic [1:0] kind;
    logic [26:0] sz;
    logic [26:0] old_b;
    logic [4:0] abits;
    logic [25:0] addr;
    for (int unsigned j = 0; j < items; j++) begin
      pb = page_bytes_now();
      kind = 2'($urandom_range(3));
      if ($urandom_range(9) < 8) sz = 27'($urandom_range(1, 6) * pb - $urandom_range(pb - 1));
      else sz = 27'($urandom());
      if ($urandom_range(3) == 0) sz = 0;
      old_b = ($urandom_range(2) == 0) ? 27'($urandom_range(1, 4) * pb) : 27'd0;
      if ($urandom_range(19) == 0) old_b = 27'($urandom());
      abits = ($urandom_range(2) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 14));
      addr = pick_address();
      if ($urandom_range(7) == 0) addr = addr + 26'($urandom_range(1, 200));
      send_item(kind, addr, sz, old_b, abits, 26'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_random_phases();
    set_geometry(1, 16);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(100);
    set_geometry(1024, 4);
    send_idle_pct = 55; recv_stall_pct = 0;  random_burst(80);
    set_geometry(3, 1023);
    send_idle_pct = 0;  recv_stall_pct = 55; random_burst(90);
    set_geometry(0, 2047);
    send_idle_pct = 27; recv_stall_pct = 27; random_burst(90);
    set_geometry(2047, 32);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(80);
    // wait out every result before the next request
    drain();
    set_geometry(2, 64);
    send_idle_pct = 27; recv_stall_pct = 27; random_burst(80);
  endtask

  initial begin
    for (int i = 0; i < pra_pkg::MAX_PAGES_DEF; i++) pages_model[i] = pra_pkg::ST_NEVER;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phases();
    drain();
    $display("Sent %0d items over seven page geometries, %0d results checked.",
             n_sent, n_checked);
    if (err_count == 0 && pending_results.size() == 0)
      $display("page_run_allocator_tb: PASS");
    else
      $display("page_run_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    #400ms;
    $display("page_run_allocator_tb: FAIL");
    $finish;
  end

endmodule
